@@ design/plcm_pkg.sv @@
// plcm_pkg: widths, payload structs and helpers for the piecewise linear colour map
// used by every module of the design folder, depends on nothing
package plcm_pkg;

   localparam int STOP_W    = 40;
   localparam int POS_W     = 16;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int RGB_W     = NUM_CHAN * CHAN_W;
   localparam int IDX_W     = 3;
   localparam int TS_W      = 24;
   localparam int NUM_W     = 25;
   localparam int DEN_W     = 24;
   localparam int DIFF_W    = 9;
   localparam int PROD_W    = 35;
   localparam int DIV_W     = 36;
   localparam int QUO_W     = 9;
   localparam int CLAMP_W   = 11;

   localparam logic [STOP_W-1:0] STOP_RESET_FIRST = 40'h00_0000_0000;
   localparam logic [STOP_W-1:0] STOP_RESET_WHITE = 40'h80_00FF_FFFF;
   localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'hFF;

   typedef logic [STOP_W-1:0] stop_type;

   // index 2 red, 1 green, 0 blue
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_a;
      logic [POS_W-1:0] pos_b;
      rgb_type          col_a;
      rgb_type          col_b;
      logic [TS_W-1:0]  ts;
   } pair_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][DIV_W-1:0] rem;
      logic [NUM_CHAN-1:0][QUO_W-1:0] quo;
      logic [NUM_CHAN-1:0]            neg;
      logic [NUM_CHAN-1:0]            sat;
      rgb_type                        base;
      logic [DEN_W:0]                 dsr;
   } work_type;

   function automatic logic [POS_W-1:0] stop_pos(input stop_type s);
      return s[STOP_W-1 -: POS_W];
   endfunction

   function automatic rgb_type stop_rgb(input stop_type s);
      return s[RGB_W-1:0];
   endfunction

   // pos * 255
   function automatic logic [TS_W-1:0] pos_scaled(input logic [POS_W-1:0] pos);
      return {pos, 8'd0} - TS_W'(pos);
   endfunction

endpackage

@@ design/piecewise_linear_color_map_top.sv @@
// piecewise_linear_color_map_top: stop registers, pipeline assembly and output clamp stage
// depends on plcm_pkg, plcm_select, plcm_setup and plcm_div_stage
//
// Maps an 8-bit intensity to a red, green, blue colour by exact linear interpolation
// between NUM_STOPS colour stops written through the csr_ port (index k writes stop
// k; bits 39:24 position in units of 1/32768, then red, green, blue bytes; the user
// must see that stops are written only while the pipeline is empty, as the block does
// not enforce it). The pipeline is fully handshaked and takes a new beat every cycle
// unless stalled; most of its depth is the nine-stage division that resolves one quotient
// bit per stage. A stalled rsp_ side fills the empty stages before req_ready drops.
module piecewise_linear_color_map_top #(
   parameter int NUM_STOPS     = 8,
   parameter int POS_FRAC_BITS = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [plcm_pkg::CHAN_W-1:0]  req_intensity,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [plcm_pkg::CHAN_W-1:0]  rsp_red,
   output logic [plcm_pkg::CHAN_W-1:0]  rsp_green,
   output logic [plcm_pkg::CHAN_W-1:0]  rsp_blue,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [plcm_pkg::IDX_W-1:0]   csr_index,
   input  logic [plcm_pkg::STOP_W-1:0]  csr_data
);
   import plcm_pkg::*;

   stop_type [NUM_STOPS-1:0]  stop_ff;

   logic                      sel_valid;
   logic                      sel_ready;
   pair_type                  sel_pair;

   logic                      node_valid [QUO_W+1];
   logic                      node_ready [QUO_W+1];
   work_type                  node_work  [QUO_W+1];

   logic                      rsp_valid_ff;
   rgb_type                   rsp_rgb_ff;
   rgb_type                   rsp_rgb_in;
   logic                      out_ready;
   logic signed [CLAMP_W-1:0] val;
   logic signed [CLAMP_W-1:0] step;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STOPS; k++) begin
            stop_ff[k] <= (k == 0) ? STOP_RESET_FIRST : STOP_RESET_WHITE;
         end
      end else begin
         for (int k = 0; k < NUM_STOPS; k++) begin
            if (csr_valid && csr_index == IDX_W'(k)) begin
               stop_ff[k] <= csr_data;
            end
         end
      end
   end

   plcm_select #(
      .NUM_STOPS     (NUM_STOPS),
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_select (
      .clock        (clock),
      .reset        (reset),
      .stops        (stop_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_intensity (req_intensity),
      .out_valid    (sel_valid),
      .out_ready    (sel_ready),
      .out_pair     (sel_pair)
   );

   plcm_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_pair   (sel_pair),
      .out_valid (node_valid[0]),
      .out_ready (node_ready[0]),
      .out_work  (node_work[0])
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      plcm_div_stage #(
         .BIT (QUO_W - 1 - i)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (node_valid[i]),
         .in_ready  (node_ready[i]),
         .in_work   (node_work[i]),
         .out_valid (node_valid[i+1]),
         .out_ready (node_ready[i+1]),
         .out_work  (node_work[i+1])
      );
   end

   assign out_ready         = !rsp_valid_ff || rsp_ready;
   assign node_ready[QUO_W] = out_ready;

   // base plus signed quotient, clamped to a byte
   always_comb begin
      val  = '0;
      step = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         step = $signed(CLAMP_W'(node_work[QUO_W].quo[ch]));
         val  = $signed(CLAMP_W'(node_work[QUO_W].base[ch])) +
                (node_work[QUO_W].neg[ch] ? -step : step);
         priority if (node_work[QUO_W].sat[ch]) begin
            rsp_rgb_in[ch] = node_work[QUO_W].neg[ch] ? '0 : CHAN_MAX;
         end else if (val < 0) begin
            rsp_rgb_in[ch] = '0;
         end else if (val > $signed(CLAMP_W'(CHAN_MAX))) begin
            rsp_rgb_in[ch] = CHAN_MAX;
         end else begin
            rsp_rgb_in[ch] = val[CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= node_valid[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_rgb_ff <= rsp_rgb_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_rgb_ff[2];
   assign rsp_green = rsp_rgb_ff[1];
   assign rsp_blue  = rsp_rgb_ff[0];

endmodule

@@ design/plcm_select.sv @@
// plcm_select: two pipeline stages that find the bracketing stop pair for an intensity
// depends on plcm_pkg
module plcm_select #(
   parameter int NUM_STOPS     = 8,
   parameter int POS_FRAC_BITS = 15
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  plcm_pkg::stop_type [NUM_STOPS-1:0]     stops,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [plcm_pkg::CHAN_W-1:0]            in_intensity,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output plcm_pkg::pair_type                     out_pair
);
   import plcm_pkg::*;

   logic                   a_valid_ff;
   logic [NUM_STOPS-2:0]   a_hit_ff;
   logic [NUM_STOPS-2:0]   a_hit_in;
   logic [TS_W-1:0]        a_ts_ff;
   logic [TS_W-1:0]        a_ts_in;
   logic                   a_ready;
   logic                   b_valid_ff;
   pair_type               b_pair_ff;
   pair_type               b_pair_in;
   logic                   b_ready;

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   // bracket flags per adjacent pair
   always_comb begin
      a_ts_in = TS_W'(in_intensity) << POS_FRAC_BITS;
      for (int k = 0; k < NUM_STOPS - 1; k++) begin
         a_hit_in[k] = (a_ts_in >= pos_scaled(stop_pos(stops[k]))) &&
                       (a_ts_in <= pos_scaled(stop_pos(stops[k+1])));
      end
   end

   // first bracketing pair wins, else first and last stop
   always_comb begin
      b_pair_in.pos_a = stop_pos(stops[0]);
      b_pair_in.col_a = stop_rgb(stops[0]);
      b_pair_in.pos_b = stop_pos(stops[NUM_STOPS-1]);
      b_pair_in.col_b = stop_rgb(stops[NUM_STOPS-1]);
      for (int k = NUM_STOPS - 2; k >= 0; k--) begin
         if (a_hit_ff[k]) begin
            b_pair_in.pos_a = stop_pos(stops[k]);
            b_pair_in.col_a = stop_rgb(stops[k]);
            b_pair_in.pos_b = stop_pos(stops[k+1]);
            b_pair_in.col_b = stop_rgb(stops[k+1]);
         end
      end
      b_pair_in.ts = a_ts_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_hit_ff <= a_hit_in;
         a_ts_ff  <= a_ts_in;
      end
      if (b_ready) begin
         b_pair_ff <= b_pair_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_pair  = b_pair_ff;

endmodule

@@ design/plcm_setup.sv @@
// plcm_setup: three pipeline stages forming numerator, denominator and dividend per channel
// depends on plcm_pkg
module plcm_setup (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  plcm_pkg::pair_type  in_pair,
   output logic                out_valid,
   input  logic                out_ready,
   output plcm_pkg::work_type  out_work
);
   import plcm_pkg::*;

   logic                      ordered;
   logic                      c_valid_ff;
   logic signed [NUM_W-1:0]   c_num_ff;
   logic signed [NUM_W-1:0]   c_num_in;
   logic [DEN_W-1:0]          c_den_ff;
   logic [DEN_W-1:0]          c_den_in;
   logic signed [DIFF_W-1:0]  c_diff_ff [NUM_CHAN];
   logic signed [DIFF_W-1:0]  c_diff_in [NUM_CHAN];
   rgb_type                   c_base_ff;
   logic                      c_ready;

   logic                      d_valid_ff;
   logic signed [PROD_W-1:0]  d_sum_ff [NUM_CHAN];
   logic signed [PROD_W-1:0]  d_sum_in [NUM_CHAN];
   logic [DEN_W-1:0]          d_den_ff;
   rgb_type                   d_base_ff;
   logic                      d_ready;

   logic                      e_valid_ff;
   work_type                  e_work_ff;
   work_type                  e_work_in;
   logic                      e_ready;

   assign c_ready  = !c_valid_ff || d_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign e_ready  = !e_valid_ff || out_ready;
   assign in_ready = c_ready;

   always_comb begin
      ordered  = in_pair.pos_b > in_pair.pos_a;
      c_num_in = ordered ? ($signed({1'b0, in_pair.ts}) -
                            $signed({1'b0, pos_scaled(in_pair.pos_a)}))
                         : '0;
      c_den_in = ordered ? pos_scaled(in_pair.pos_b - in_pair.pos_a) : DEN_W'(1);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         c_diff_in[ch] = $signed({1'b0, in_pair.col_b[ch]}) -
                         $signed({1'b0, in_pair.col_a[ch]});
      end
   end

   // 2*(b-a)*num + den
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         d_sum_in[ch] = ((PROD_W'(c_diff_ff[ch]) * PROD_W'(c_num_ff)) <<< 1) +
                        $signed(PROD_W'(c_den_ff));
      end
   end

   // floor of a negative quotient taken as minus ceiling of the magnitude
   always_comb begin
      e_work_in.dsr  = {d_den_ff, 1'b0};
      e_work_in.base = d_base_ff;
      e_work_in.quo  = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         e_work_in.neg[ch] = d_sum_ff[ch][PROD_W-1];
         e_work_in.rem[ch] = e_work_in.neg[ch]
                           ? (DIV_W'(e_work_in.dsr) + DIV_W'($unsigned(~d_sum_ff[ch])))
                           : DIV_W'($unsigned(d_sum_ff[ch]));
         e_work_in.sat[ch] = e_work_in.rem[ch] >= (DIV_W'(e_work_in.dsr) << QUO_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (c_ready) begin
            c_valid_ff <= in_valid;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
         if (e_ready) begin
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_num_ff  <= c_num_in;
         c_den_ff  <= c_den_in;
         c_diff_ff <= c_diff_in;
         c_base_ff <= in_pair.col_a;
      end
      if (d_ready) begin
         d_sum_ff  <= d_sum_in;
         d_den_ff  <= c_den_ff;
         d_base_ff <= c_base_ff;
      end
      if (e_ready) begin
         e_work_ff <= e_work_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_work  = e_work_ff;

endmodule

@@ design/plcm_div_stage.sv @@
// plcm_div_stage: one restoring division stage, resolves one quotient bit for all channels
// depends on plcm_pkg
module plcm_div_stage #(
   parameter int BIT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  plcm_pkg::work_type  in_work,
   output logic                out_valid,
   input  logic                out_ready,
   output plcm_pkg::work_type  out_work
);
   import plcm_pkg::*;

   logic              valid_ff;
   work_type          work_ff;
   work_type          work_in;
   logic [DIV_W-1:0]  shifted;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      work_in = in_work;
      shifted = DIV_W'(in_work.dsr) << BIT;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         if (in_work.rem[ch] >= shifted) begin
            work_in.rem[ch]      = in_work.rem[ch] - shifted;
            work_in.quo[ch][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule
